/* sv/csp_pkg.sv */
// Shared types and constants of the cubic spline point evaluator.
package csp_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_W = 6;
   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int NUM_TAPS = 4;
   localparam int NUM_AXES = 3;
   localparam int COORD_W = 32;
   localparam int FRAC_W = 17;
   localparam int COEF_W = 16;
   localparam int CSR_W = 64;
   localparam int CSR_IDX_W = 2;
   localparam int SLOT_SPAN = (1 << IDX_W) + NUM_TAPS - 1;
   localparam int SLOT_SEL_W = $clog2(SLOT_SPAN);

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_EVAL = 1'b1
   } req_kind_type;

   typedef logic [NUM_AXES-1:0][COORD_W-1:0] point_type;
   typedef logic [NUM_TAPS-1:0][CSR_W-1:0] coef_bank_type;
   typedef logic [ADDR_W-1:0] slot_lut_type [SLOT_SPAN];

   // Catmull-Rom basis with the half folded in, one power of t per word
   localparam coef_bank_type COEF_RESET = {
      64'd576715839403784192,
      64'd17870318509402099712,
      64'd8796093085696,
      64'd268435456
   };

   // Table slot of start index plus tap offset, wrapped at the table size
   function automatic slot_lut_type build_slot_lut();
      slot_lut_type lut;
      for (int i = 0; i < SLOT_SPAN; i++) begin
         lut[i] = ADDR_W'(i % MAX_POINTS);
      end
      return lut;
   endfunction

   localparam slot_lut_type SLOT_LUT = build_slot_lut();

endpackage

/* sv/csp_if.sv */
// Request and response channel interfaces of the spline evaluator.
interface csp_req_if;
   logic                                 valid;
   logic                                 ready;
   csp_pkg::req_kind_type                req_type;
   logic [csp_pkg::IDX_W-1:0]            point_index;
   logic signed [csp_pkg::COORD_W-1:0]   coord_x;
   logic signed [csp_pkg::COORD_W-1:0]   coord_y;
   logic signed [csp_pkg::COORD_W-1:0]   coord_z;
   logic [csp_pkg::FRAC_W-1:0]           fraction;

   modport source (output valid, req_type, point_index, coord_x, coord_y, coord_z, fraction,
                   input ready);
   modport sink (input valid, req_type, point_index, coord_x, coord_y, coord_z, fraction,
                 output ready);
endinterface

interface csp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [csp_pkg::COORD_W-1:0]   pos_x;
   logic signed [csp_pkg::COORD_W-1:0]   pos_y;
   logic signed [csp_pkg::COORD_W-1:0]   pos_z;

   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

/* sv/csp_ram.sv */
// Generic single write port, single read port RAM with registered read.
module csp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/cubic_spline_point_eval.sv */
// Spline point evaluator: a load beat writes one control point into the table and returns
// nothing; an evaluate beat reads four consecutive points (wrapping at the table end) and
// returns their weighted sum, the weights being [1 t t^2 t^3] times the programmable basis.
// One beat is taken every cycle unless the output stalls. A result passes through six
// register stages: table read with t squared, t cubed, basis products, weight sum and round,
// point products, and the final sum with round and saturation. The table is held as four
// copies of a MAX_POINTS-entry RAM, one per tap, so that all four points come out in the
// same cycle; it has no clearing pass and must be loaded before use. Basis registers are
// written through the csr port while no evaluation is in flight; a user duty, not enforced.
module cubic_spline_point_eval (
   input  logic                        clock,
   input  logic                        reset,
   csp_req_if.sink                     req_bus,
   csp_rsp_if.source                   rsp_bus,
   input  logic                        csr_wr_en,
   input  logic [csp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [csp_pkg::CSR_W-1:0]   csr_wr_data
);

   localparam int NT = csp_pkg::NUM_TAPS;
   localparam int NA = csp_pkg::NUM_AXES;
   localparam int TP_W = 19;          // widest power of t, t cubed
   localparam int BPROD_W = 36;       // coefficient times power
   localparam int RAW_W = 38;
   localparam int W_W = RAW_W - 12;   // weight, Q.16
   localparam int PPROD_W = csp_pkg::COORD_W + W_W;
   localparam int ACC_W = PPROD_W + 2;
   localparam int RES_W = ACC_W - 16;

   // basis registers
   csp_pkg::coef_bank_type coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= csp_pkg::COEF_RESET;
      end else if (csr_wr_en) begin
         coef_ff[csr_index] <= csr_wr_data;
      end
   end

   // stage handshake: a stage may load when empty or when the next one loads
   logic [6:1] v_ff;
   logic [6:1] v_in;
   logic [6:1] ld;
   logic       req_acc;
   logic       eval_acc;
   logic       load_acc;

   always_comb begin
      ld[6] = !v_ff[6] || rsp_bus.ready;
      for (int i = 5; i >= 1; i--) begin
         ld[i] = !v_ff[i] || ld[i+1];
      end
   end

   assign req_bus.ready = ld[1];
   assign req_acc  = req_bus.valid && ld[1];
   assign eval_acc = req_acc && (req_bus.req_type == csp_pkg::REQ_EVAL);
   assign load_acc = req_acc && (req_bus.req_type == csp_pkg::REQ_LOAD);

   always_comb begin
      v_in[1] = ld[1] ? eval_acc : v_ff[1];
      for (int i = 2; i <= 6; i++) begin
         v_in[i] = ld[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // point table, one copy per tap
   logic                                wr_en;
   logic [csp_pkg::ADDR_W-1:0]          wr_addr;
   csp_pkg::point_type                  wr_point;
   csp_pkg::point_type                  rd_point [NT];

   assign wr_en = load_acc && (32'(req_bus.point_index) < 32'(csp_pkg::MAX_POINTS));
   assign wr_addr = csp_pkg::SLOT_LUT[csp_pkg::SLOT_SEL_W'(req_bus.point_index)];
   assign wr_point = {req_bus.coord_z, req_bus.coord_y, req_bus.coord_x};

   for (genvar k = 0; k < NT; k++) begin : g_tap
      logic [csp_pkg::ADDR_W-1:0] rd_addr;
      assign rd_addr = csp_pkg::SLOT_LUT[csp_pkg::SLOT_SEL_W'(req_bus.point_index)
                                         + csp_pkg::SLOT_SEL_W'(k)];
      csp_ram #(
         .WIDTH ($bits(csp_pkg::point_type)),
         .DEPTH (csp_pkg::MAX_POINTS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (wr_point),
         .rd_en   (eval_acc),
         .rd_addr (rd_addr),
         .rd_data (rd_point[k])
      );
   end

   // stage 1: t and rounded t squared
   logic [csp_pkg::FRAC_W-1:0]   s1_t_ff;
   logic [17:0]                  s1_t2_ff;
   logic [2*csp_pkg::FRAC_W:0]   s1_tsq;
   logic [17:0]                  s1_t2_in;

   assign s1_tsq = (2*csp_pkg::FRAC_W+1)'(req_bus.fraction * req_bus.fraction)
                   + (2*csp_pkg::FRAC_W+1)'(32768);
   assign s1_t2_in = s1_tsq[33:16];

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         s1_t_ff  <= req_bus.fraction;
         s1_t2_ff <= s1_t2_in;
      end
   end

   // stage 2: rounded t cubed, points leave the RAM
   logic [NT-1:0][TP_W-1:0] s2_tp_ff;
   logic [NT-1:0][TP_W-1:0] s2_tp_in;
   csp_pkg::point_type      s2_pts_ff [NT];
   logic [35:0]             s2_tcube;

   assign s2_tcube = 36'(s1_t2_ff * s1_t_ff) + 36'(32768);

   always_comb begin
      s2_tp_in[0] = TP_W'(65536);
      s2_tp_in[1] = TP_W'(s1_t_ff);
      s2_tp_in[2] = TP_W'(s1_t2_ff);
      s2_tp_in[3] = s2_tcube[34:16];
   end

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         s2_tp_ff  <= s2_tp_in;
         s2_pts_ff <= rd_point;
      end
   end

   // stage 3: coefficient times power of t, for every tap and power
   logic signed [BPROD_W-1:0] s3_prod_ff [NT][NT];
   logic signed [BPROD_W-1:0] s3_prod_in [NT][NT];
   csp_pkg::point_type        s3_pts_ff [NT];

   always_comb begin
      for (int k = 0; k < NT; k++) begin
         for (int j = 0; j < NT; j++) begin
            s3_prod_in[k][j] = $signed(coef_ff[j][csp_pkg::COEF_W*k +: csp_pkg::COEF_W])
                               * $signed({1'b0, s2_tp_ff[j]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         s3_prod_ff <= s3_prod_in;
         s3_pts_ff  <= s2_pts_ff;
      end
   end

   // stage 4: weights, sum over powers rounded to Q.16
   logic signed [W_W-1:0]   s4_w_ff [NT];
   logic signed [W_W-1:0]   s4_w_in [NT];
   logic signed [RAW_W-1:0] s4_raw [NT];
   csp_pkg::point_type      s4_pts_ff [NT];

   always_comb begin
      for (int k = 0; k < NT; k++) begin
         s4_raw[k] = RAW_W'(s3_prod_ff[k][0]) + RAW_W'(s3_prod_ff[k][1])
                   + RAW_W'(s3_prod_ff[k][2]) + RAW_W'(s3_prod_ff[k][3])
                   + RAW_W'(2048);
         s4_w_in[k] = s4_raw[k][RAW_W-1:12];
      end
   end

   always_ff @(posedge clock) begin
      if (ld[4]) begin
         s4_w_ff   <= s4_w_in;
         s4_pts_ff <= s3_pts_ff;
      end
   end

   // stage 5: point times weight, per axis and tap
   logic signed [PPROD_W-1:0] s5_prod_ff [NA][NT];
   logic signed [PPROD_W-1:0] s5_prod_in [NA][NT];

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         for (int k = 0; k < NT; k++) begin
            s5_prod_in[a][k] = $signed(s4_pts_ff[k][a]) * s4_w_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[5]) begin
         s5_prod_ff <= s5_prod_in;
      end
   end

   // stage 6: sum, round to Q16.16 and saturate into the output register
   logic signed [csp_pkg::COORD_W-1:0] s6_pos_ff [NA];
   logic signed [csp_pkg::COORD_W-1:0] s6_pos_in [NA];
   logic signed [ACC_W-1:0]            s6_acc [NA];
   logic signed [RES_W-1:0]            s6_res [NA];

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         s6_acc[a] = ACC_W'(s5_prod_ff[a][0]) + ACC_W'(s5_prod_ff[a][1])
                   + ACC_W'(s5_prod_ff[a][2]) + ACC_W'(s5_prod_ff[a][3])
                   + ACC_W'(32768);
         s6_res[a] = s6_acc[a][ACC_W-1:16];
         // in range when every bit above the sign of the 32-bit word agrees
         if (&s6_res[a][RES_W-1:csp_pkg::COORD_W-1] || ~|s6_res[a][RES_W-1:csp_pkg::COORD_W-1]) begin
            s6_pos_in[a] = s6_res[a][csp_pkg::COORD_W-1:0];
         end else if (s6_res[a][RES_W-1]) begin
            s6_pos_in[a] = {1'b1, {(csp_pkg::COORD_W-1){1'b0}}};
         end else begin
            s6_pos_in[a] = {1'b0, {(csp_pkg::COORD_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[6]) begin
         s6_pos_ff <= s6_pos_in;
      end
   end

   assign rsp_bus.valid = v_ff[6];
   assign rsp_bus.pos_x = s6_pos_ff[0];
   assign rsp_bus.pos_y = s6_pos_ff[1];
   assign rsp_bus.pos_z = s6_pos_ff[2];

endmodule

/* sv/csp_checker.sv */
// Port-level checks of the spline evaluator, bound to the top level.
module csp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [csp_pkg::COORD_W-1:0] pos_x,
   input logic signed [csp_pkg::COORD_W-1:0] pos_y,
   input logic signed [csp_pkg::COORD_W-1:0] pos_z
);

   // nothing can come out sooner than the pipeline depth after reset
   a_no_early_result: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid ##1 !rsp_valid
                ##1 !rsp_valid ##1 !rsp_valid)
      else $error("result beat within pipeline depth of reset");

   // a free or draining output means every stage can move, so input is open
   a_ready_when_out_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input blocked while output is free");

   // a refused result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(pos_x) && $stable(pos_y) && $stable(pos_z)))
      else $error("stalled result beat changed");

   // input valid is watched so a stuck-low ready under load shows up in traces
   a_req_taken_when_free: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !rsp_valid) |-> req_ready)
      else $error("request refused with empty output");

endmodule

bind cubic_spline_point_eval csp_checker u_csp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .pos_x     (rsp_bus.pos_x),
   .pos_y     (rsp_bus.pos_y),
   .pos_z     (rsp_bus.pos_z)
);
